[design/page_translation_cache_ring_macros.svh]
// ----------------------------------------------------------------------------
// page translation cache ring assertion macros
// shared property wrappers, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef PAGE_TRANSLATION_CACHE_RING_MACROS_SVH
`define PAGE_TRANSLATION_CACHE_RING_MACROS_SVH

// same-cycle implication
`define PTC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptc assertion failed");

// next-cycle implication
`define PTC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptc assertion failed");

`endif

[design/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// sizes, entry layout and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptc_pkg;

    localparam int NUM_ENTRIES   = 16;
    localparam int NEAR_DISTANCE = 4;

    localparam int ADDR_W = 64;
    localparam int OFF_W  = 12;
    localparam int PAGE_W = ADDR_W - OFF_W;

    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam int FAR_W = $clog2(NUM_ENTRIES + NEAR_DISTANCE + 1);

    typedef struct packed {
        logic [PAGE_W-1:0] virt_page;
        logic [PAGE_W-1:0] host_page;
        logic              can_write;
    } entry_t;

    typedef struct packed {
        logic load_item;     // latch the accepted item, restart the scan
        logic scan;          // issue the next ring read
        logic capture_hit;   // keep the matching entry and its slot
        logic rd_before;     // read the slot before the head
        logic wr_hit_before; // hit entry into the slot before the head, head moves
        logic wr_old_hit;    // old contents of that slot into the hit slot
        logic fill_write;    // new entry into the slot before the head, head moves
        logic load_out;      // result into the output register
    } ptc_cmd_t;

    typedef struct packed {
        logic fill_req;  // func of the item on the input port
        logic match;     // compare stage holds a usable entry
        logic far;       // that entry lies at or beyond the near distance
        logic scan_done; // every slot compared, nothing found
        logic out_free;  // output register can take a result this cycle
    } ptc_status_t;

endpackage

[design/ptc_ctrl.sv]
// ----------------------------------------------------------------------------
// ptc_ctrl
// sequencer for fill, ring scan and move-to-front swap
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_ctrl
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  ptc_status_t status,
    output ptc_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FILL    = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_SWAP_RD = 3'd3;
    localparam logic [2:0] ST_SWAP_WA = 3'd4;
    localparam logic [2:0] ST_SWAP_WB = 3'd5;
    localparam logic [2:0] ST_RESULT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = status.fill_req ? ST_FILL : ST_SCAN;
                end
            end
            ST_FILL:
            begin
                cmd.fill_write = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_SCAN:
            begin
                priority if (status.match)
                begin
                    cmd.capture_hit = 1'b1;
                    state_next      = status.far ? ST_SWAP_RD : ST_RESULT;
                end
                else if (status.scan_done)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            ST_SWAP_RD:
            begin
                cmd.rd_before = 1'b1;
                state_next    = ST_SWAP_WA;
            end
            ST_SWAP_WA:
            begin
                cmd.wr_hit_before = 1'b1;
                state_next        = ST_SWAP_WB;
            end
            ST_SWAP_WB:
            begin
                cmd.wr_old_hit = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[design/ptc_datapath.sv]
// ----------------------------------------------------------------------------
// ptc_datapath
// entry memory, valid bits, head pointer, scan compare and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptc_datapath
    import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ptc_cmd_t           cmd,
    output ptc_status_t        status,
    input  logic               func,
    input  logic [ADDR_W-1:0]  vaddr,
    input  logic               write_access,
    input  logic [PAGE_W-1:0]  fill_host_page,
    input  logic               fill_writable,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic [ADDR_W-1:0]  host_addr
);

    entry_t mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]       head_reg;

    // latched item
    logic [PAGE_W-1:0] item_page_reg;
    logic [OFF_W-1:0]  item_off_reg;
    logic              item_wr_reg;
    logic [PAGE_W-1:0] item_host_reg;
    logic              item_cw_reg;

    // scan state
    logic [CNT_W-1:0] iss_reg;
    logic             cmp_valid_reg;
    logic [IDX_W-1:0] cmp_dist_reg;
    logic [IDX_W-1:0] cmp_slot_reg;

    // read port
    entry_t           rd_entry_reg;
    logic             rd_vbit_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;

    // hit holding
    entry_t           hold_reg;
    logic [IDX_W-1:0] hit_slot_reg;
    logic             res_hit_reg;

    // write port
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_entry;
    logic             wr_vbit;
    logic             head_move;

    logic [IDX_W-1:0] before_slot;
    logic [SUM_W-1:0] ring_sum;
    logic [SUM_W-1:0] ring_wrap;
    logic [IDX_W-1:0] scan_addr;
    logic             scan_issue;

    logic out_valid_reg;
    logic hit_reg;
    logic [ADDR_W-1:0] host_addr_reg;

    assign before_slot = (head_reg == '0) ? IDX_W'(NUM_ENTRIES - 1) : head_reg - 1'b1;

    // head plus distance, wrapped once around the ring
    assign ring_sum  = {1'b0, head_reg} + SUM_W'(iss_reg);
    assign ring_wrap = (ring_sum >= SUM_W'(NUM_ENTRIES)) ?
                       ring_sum - SUM_W'(NUM_ENTRIES) : ring_sum;
    assign scan_addr = ring_wrap[IDX_W-1:0];

    assign scan_issue = cmd.scan && (iss_reg != CNT_W'(NUM_ENTRIES));
    assign rd_en      = scan_issue || cmd.rd_before;
    assign rd_addr    = cmd.rd_before ? before_slot : scan_addr;

    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = before_slot;
        wr_entry  = hold_reg;
        wr_vbit   = 1'b1;
        head_move = 1'b0;
        priority if (cmd.fill_write)
        begin
            wr_en     = 1'b1;
            wr_entry  = '{virt_page: item_page_reg, host_page: item_host_reg,
                          can_write: item_cw_reg};
            head_move = 1'b1;
        end
        else if (cmd.wr_hit_before)
        begin
            wr_en     = 1'b1;
            head_move = 1'b1;
        end
        else if (cmd.wr_old_hit)
        begin
            wr_en    = 1'b1;
            wr_addr  = hit_slot_reg;
            wr_entry = rd_entry_reg;
            wr_vbit  = rd_vbit_reg;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
            rd_vbit_reg  <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            head_reg      <= '0;
            iss_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            res_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= wr_vbit;
            end
            if (head_move)
            begin
                head_reg <= before_slot;
            end
            if (cmd.load_item)
            begin
                iss_reg <= '0;
            end
            else if (scan_issue)
            begin
                iss_reg <= iss_reg + 1'b1;
            end
            cmp_valid_reg <= scan_issue;
            if (cmd.load_item)
            begin
                res_hit_reg <= 1'b0;
            end
            else if (cmd.capture_hit)
            begin
                res_hit_reg <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_page_reg <= vaddr[ADDR_W-1:OFF_W];
            item_off_reg  <= vaddr[OFF_W-1:0];
            item_wr_reg   <= write_access;
            item_host_reg <= fill_host_page;
            item_cw_reg   <= fill_writable;
        end
        if (scan_issue)
        begin
            cmp_dist_reg <= iss_reg[IDX_W-1:0];
            cmp_slot_reg <= scan_addr;
        end
        if (cmd.capture_hit)
        begin
            hold_reg     <= rd_entry_reg;
            hit_slot_reg <= cmp_slot_reg;
        end
        if (cmd.load_out)
        begin
            hit_reg       <= res_hit_reg;
            host_addr_reg <= res_hit_reg ? {hold_reg.host_page, item_off_reg} : '0;
        end
    end

    assign status.fill_req  = func;
    assign status.match     = cmp_valid_reg && rd_vbit_reg &&
                              (rd_entry_reg.virt_page == item_page_reg) &&
                              (rd_entry_reg.can_write || !item_wr_reg);
    assign status.far       = (FAR_W'(cmp_dist_reg) >= FAR_W'(NEAR_DISTANCE));
    assign status.scan_done = !cmp_valid_reg && (iss_reg == CNT_W'(NUM_ENTRIES));
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign host_addr = host_addr_reg;

endmodule

[design/page_translation_cache_ring.sv]
// ----------------------------------------------------------------------------
// page_translation_cache_ring
// fully associative 4 KiB page translation cache, ring order, move to front
// ----------------------------------------------------------------------------
// usage
// - input channel in_valid/in_stall carries func, vaddr, write_access,
//   fill_host_page and fill_writable; one transfer per item
// - output channel out_valid/out_stall carries hit and host_addr; every
//   item, lookup or fill, gives exactly one result transfer
// - one item is in the block at a time; in_stall is high from the cycle
//   after a transfer until the result sits in the output register
// - fill: the new entry is written into the slot before the head
// - lookup: the scan compares entries from the head on; a hit at or beyond
//   NEAR_DISTANCE is moved to front first; a miss compares every slot
// - the scan reads one entry per cycle through the single read port of the
//   entry memory, the swap takes one read and two writes on that memory
// - a finished result waits in the output register while out_stall is
//   high; the next item is still taken and works up to its result
// - reset clears all valid bits, the head and the handshakes at once; no
//   clearing pass, the block takes items in the first cycle after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "page_translation_cache_ring_macros.svh"

module page_translation_cache_ring
    import ptc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [ADDR_W-1:0] vaddr,
    input  logic              write_access,
    input  logic [PAGE_W-1:0] fill_host_page,
    input  logic              fill_writable,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    output logic [ADDR_W-1:0] host_addr
);

    ptc_cmd_t    cmd;
    ptc_status_t status;

    ptc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ptc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .func           (func),
        .vaddr          (vaddr),
        .write_access   (write_access),
        .fill_host_page (fill_host_page),
        .fill_writable  (fill_writable),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .host_addr      (host_addr)
    );

    // an accepted item always keeps the block busy for the next cycle
    `PTC_ASSERT_NXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
    // a miss or fill result carries a zero address
    `PTC_ASSERT_IMP(a_miss_zero_addr, out_valid && !hit, host_addr == '0)
    // a new result is only loaded while an item is in flight
    `PTC_ASSERT_IMP(a_result_from_item, $rose(out_valid), $past(in_stall))

endmodule
